/* src/lpcd_pkg.sv */
// Shared types for the length-prefixed chunk deframer.
package lpcd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned ErrW  = 2;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE     = 2'd0,
    ERR_LONE     = 2'd1,
    ERR_MSG_LONG = 2'd2
  } err_t;

  typedef enum logic [7:0] {
    PH_CHUNK_LO  = 8'b0000_0001,
    PH_CHUNK_HI  = 8'b0000_0010,
    PH_MSG_LO    = 8'b0000_0100,
    PH_MSG_HI    = 8'b0000_1000,
    PH_MSG_FIRST = 8'b0001_0000,
    PH_MSG_BODY  = 8'b0010_0000,
    PH_RAW       = 8'b0100_0000,
    PH_DISCARD   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] payload;
    logic             byte_valid;
    logic             message_start;
    logic             message_end;
    logic             chunk_end;
    err_t             error_code;
  } result_t;

endpackage

/* src/length_prefixed_chunk_deframer_core.sv */
// Deframer core: 16-bit little-endian chunk and message length parser.
// Results are registered: in the result register, or in the skid if that one is stalled.
// Throughput: one byte per cycle while the skid is empty; only the per-byte counter update
//   and length compare stand between the parser state and the result register.
// A two-entry output (result register plus skid) keeps input flowing while a result waits.
// Reset (rst, synchronous): expect a chunk length low byte, counters zero, message mode on.
module length_prefixed_chunk_deframer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      data_valid,
  output logic                      data_stall,
  input  logic [lpcd_pkg::ByteW-1:0] data_byte,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [lpcd_pkg::ByteW-1:0] payload,
  output logic                      byte_valid,
  output logic                      message_start,
  output logic                      message_end,
  output logic                      chunk_end,
  output logic [lpcd_pkg::ErrW-1:0] error_code
);
  import lpcd_pkg::*;

  // Parser state
  logic              split_messages;
  phase_t            phase, phase_next;
  logic [LenW-1:0]   chunk_left, chunk_left_next;
  logic [LenW-1:0]   message_left, message_left_next;
  logic [ByteW-1:0]  length_low_hold, length_low_hold_next;

  // Output stage: result register plus one skid entry
  result_t           result, skid;
  logic              skid_valid;

  // Combinational result of the current beat
  result_t           beat_res;
  logic              beat_emit;

  logic              accept;
  logic              take;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   chunk_dec;
  logic [LenW-1:0]   message_dec;

  // The skid entry is the only thing that can block the input side.
  assign data_stall = skid_valid;
  assign accept     = data_valid && !data_stall;
  assign take       = result_valid && !result_stall;

  assign len         = {data_byte, length_low_hold};
  // Saturating decrements, as the counters never go below zero.
  assign chunk_dec   = (chunk_left   != '0) ? chunk_left   - LenW'(1) : '0;
  assign message_dec = (message_left != '0) ? message_left - LenW'(1) : '0;

  always_comb begin
    phase_next           = phase;
    chunk_left_next      = chunk_left;
    message_left_next    = message_left;
    length_low_hold_next = length_low_hold;
    beat_emit            = 1'b0;
    beat_res             = '{payload: '0, byte_valid: 1'b0, message_start: 1'b0,
                             message_end: 1'b0, chunk_end: 1'b0, error_code: ERR_NONE};
    unique case (phase)
      PH_CHUNK_LO: begin
        length_low_hold_next = data_byte;
        phase_next           = PH_CHUNK_HI;
      end
      PH_CHUNK_HI: begin
        if (len == '0) begin
          // Empty chunk: one marker closes it.
          phase_next         = PH_CHUNK_LO;
          beat_emit          = 1'b1;
          beat_res.chunk_end = 1'b1;
        end else begin
          // Sample the mode here; it holds for the whole chunk.
          chunk_left_next = len;
          phase_next      = split_messages ? PH_MSG_LO : PH_RAW;
        end
      end
      PH_MSG_LO: begin
        if (chunk_left <= LenW'(1)) begin
          // Lone trailing byte: no room for a message header.
          chunk_left_next     = '0;
          phase_next          = PH_CHUNK_LO;
          beat_emit           = 1'b1;
          beat_res.chunk_end  = 1'b1;
          beat_res.error_code = ERR_LONE;
        end else begin
          length_low_hold_next = data_byte;
          chunk_left_next      = chunk_dec;
          phase_next           = PH_MSG_HI;
        end
      end
      PH_MSG_HI: begin
        chunk_left_next = chunk_dec;
        if (len > chunk_dec) begin
          // Message too long: flag it, then drop the rest of the chunk.
          beat_emit           = 1'b1;
          beat_res.error_code = ERR_MSG_LONG;
          if (chunk_dec == '0) begin
            phase_next         = PH_CHUNK_LO;
            beat_res.chunk_end = 1'b1;
          end else begin
            phase_next = PH_DISCARD;
          end
        end else if (len == '0) begin
          // Empty message marker.
          phase_next             = (chunk_dec == '0) ? PH_CHUNK_LO : PH_MSG_LO;
          beat_emit              = 1'b1;
          beat_res.message_start = 1'b1;
          beat_res.message_end   = 1'b1;
          beat_res.chunk_end     = (chunk_dec == '0);
        end else begin
          message_left_next = len;
          phase_next        = PH_MSG_FIRST;
        end
      end
      PH_MSG_FIRST, PH_MSG_BODY: begin
        message_left_next = message_dec;
        chunk_left_next   = chunk_dec;
        priority if (chunk_dec == '0) begin
          phase_next = PH_CHUNK_LO;
        end else if (message_dec == '0) begin
          phase_next = PH_MSG_LO;
        end else begin
          phase_next = PH_MSG_BODY;
        end
        beat_emit              = 1'b1;
        beat_res.payload       = data_byte;
        beat_res.byte_valid    = 1'b1;
        beat_res.message_start = (phase == PH_MSG_FIRST);
        beat_res.message_end   = (message_dec == '0);
        beat_res.chunk_end     = (chunk_dec == '0);
      end
      PH_RAW: begin
        chunk_left_next = chunk_dec;
        if (chunk_dec == '0) begin
          phase_next = PH_CHUNK_LO;
        end
        beat_emit           = 1'b1;
        beat_res.payload    = data_byte;
        beat_res.byte_valid = 1'b1;
        beat_res.chunk_end  = (chunk_dec == '0);
      end
      PH_DISCARD: begin
        // Drop bytes silently; only the last one closes the chunk.
        chunk_left_next = chunk_dec;
        if (chunk_dec == '0) begin
          phase_next         = PH_CHUNK_LO;
          beat_emit          = 1'b1;
          beat_res.chunk_end = 1'b1;
        end
      end
      default: begin
        phase_next = PH_CHUNK_LO;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      split_messages <= 1'b1;
    end else if (cfg_wr_en) begin
      split_messages <= cfg_wr_data;
    end
  end

  // Advance the parser on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CHUNK_LO;
      chunk_left      <= '0;
      message_left    <= '0;
      length_low_hold <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      chunk_left      <= chunk_left_next;
      message_left    <= message_left_next;
      length_low_hold <= length_low_hold_next;
    end
  end

  // Output register and skid entry control. While the skid is full no beat
  // is accepted, so the only job then is to drain it into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && beat_emit) begin
      if (result_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  // Payload of the output stage; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (accept && beat_emit) begin
      if (result_valid && !take) begin
        skid <= beat_res;
      end else begin
        result <= beat_res;
      end
    end
  end

  assign payload       = result.payload;
  assign byte_valid    = result.byte_valid;
  assign message_start = result.message_start;
  assign message_end   = result.message_end;
  assign chunk_end     = result.chunk_end;
  assign error_code    = result.error_code;

  // The skid entry only ever fills behind an occupied result register.
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds a beat while the result register is empty");

  // The skid fills only when a held result was stalled.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid entry filled without a stalled result");

  // A marker result never carries a data byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !byte_valid) |-> (payload == '0))
    else $error("marker result carries a nonzero payload");

  // Errors never come with a data byte or message marks.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (error_code != ERR_NONE)) |->
      (!byte_valid && !message_start && !message_end))
    else $error("error result carries data or message marks");

endmodule

/* tb/length_prefixed_chunk_deframer_core_tb.sv */
// Self-checking testbench for the length-prefixed chunk deframer core.
module length_prefixed_chunk_deframer_core_tb;
  import lpcd_pkg::*;

  // Cycles to let pass after the last result before touching the mode
  // register: margin for the registered result and the two-entry output.
  localparam int unsigned DRAIN_CYCLES = 4;
  // Cycles with no beat on either side before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 1000;
  localparam int unsigned SHOWN_FAILS = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 data_valid = 1'b0;
  logic                 data_stall;
  logic [ByteW-1:0]     data_byte = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ByteW-1:0]     payload;
  logic                 byte_valid;
  logic                 message_start;
  logic                 message_end;
  logic                 chunk_end;
  logic [ErrW-1:0]      error_code;

  // Parser mirror: what the deframer should be holding after each beat.
  phase_t               parse_ph = PH_CHUNK_LO;
  logic [LenW-1:0]      chunk_rem = '0;
  logic [LenW-1:0]      msg_rem = '0;
  logic [ByteW-1:0]     len_lo = '0;
  bit                   split_on = 1'b1;

  result_t              deframed_q[$];
  int unsigned          fail_count = 0;
  int unsigned          bytes_sent = 0;
  bit                   gaps_on = 1'b1;

  length_prefixed_chunk_deframer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .payload       (payload),
    .byte_valid    (byte_valid),
    .message_start (message_start),
    .message_end   (message_end),
    .chunk_end     (chunk_end),
    .error_code    (error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the parser mirror by one input byte. Returns 1 when that byte
  // closes out a result beat, which is handed back in r.
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [LenW-1:0] len;
    bit              has;
    r   = '0;
    has = 1'b0;
    case (parse_ph)
      PH_CHUNK_HI: begin
        len = {b, len_lo};
        if (len == 0) begin
          // Empty chunk: a bare chunk-end marker.
          parse_ph    = PH_CHUNK_LO;
          r.chunk_end = 1'b1;
          has         = 1'b1;
        end else begin
          // Mode is latched here, so a register write mid-chunk waits for the next one.
          chunk_rem = len;
          parse_ph  = split_on ? PH_MSG_LO : PH_RAW;
        end
      end
      PH_MSG_LO: begin
        if (chunk_rem <= 1) begin
          // Lone trailing byte where a message header should start.
          chunk_rem    = '0;
          parse_ph     = PH_CHUNK_LO;
          r.chunk_end  = 1'b1;
          r.error_code = ERR_LONE;
          has          = 1'b1;
        end else begin
          len_lo    = b;
          chunk_rem = chunk_rem - 1'b1;
          parse_ph  = PH_MSG_HI;
        end
      end
      PH_MSG_HI: begin
        if (chunk_rem != 0) chunk_rem = chunk_rem - 1'b1;
        len = {b, len_lo};
        if (len > chunk_rem) begin
          // Message runs past the chunk: flag it, then drop the rest of the chunk.
          r.error_code = ERR_MSG_LONG;
          has          = 1'b1;
          if (chunk_rem == 0) begin
            parse_ph    = PH_CHUNK_LO;
            r.chunk_end = 1'b1;
          end else begin
            parse_ph = PH_DISCARD;
          end
        end else if (len == 0) begin
          // Empty message: one marker with both message marks.
          r.message_start = 1'b1;
          r.message_end   = 1'b1;
          r.chunk_end     = (chunk_rem == 0);
          parse_ph        = (chunk_rem == 0) ? PH_CHUNK_LO : PH_MSG_LO;
          has             = 1'b1;
        end else begin
          msg_rem  = len;
          parse_ph = PH_MSG_FIRST;
        end
      end
      PH_MSG_FIRST, PH_MSG_BODY: begin
        r.message_start = (parse_ph == PH_MSG_FIRST);
        if (msg_rem != 0) msg_rem = msg_rem - 1'b1;
        if (chunk_rem != 0) chunk_rem = chunk_rem - 1'b1;
        if (chunk_rem == 0) parse_ph = PH_CHUNK_LO;
        else if (msg_rem == 0) parse_ph = PH_MSG_LO;
        else parse_ph = PH_MSG_BODY;
        r.payload     = b;
        r.byte_valid  = 1'b1;
        r.message_end = (msg_rem == 0);
        r.chunk_end   = (chunk_rem == 0);
        has           = 1'b1;
      end
      PH_RAW: begin
        // Chunk mode: pass bytes through, no message marks.
        if (chunk_rem != 0) chunk_rem = chunk_rem - 1'b1;
        if (chunk_rem == 0) parse_ph = PH_CHUNK_LO;
        r.payload    = b;
        r.byte_valid = 1'b1;
        r.chunk_end  = (chunk_rem == 0);
        has          = 1'b1;
      end
      PH_DISCARD: begin
        // Only the last dropped byte reports, and only as a chunk end.
        if (chunk_rem != 0) chunk_rem = chunk_rem - 1'b1;
        if (chunk_rem == 0) begin
          parse_ph    = PH_CHUNK_LO;
          r.chunk_end = 1'b1;
          has         = 1'b1;
        end
      end
      default: begin
        len_lo   = b;
        parse_ph = PH_CHUNK_HI;
      end
    endcase
    return has;
  endfunction

  // Drive one byte and hold it until the deframer takes it. Acceptance is
  // judged from stall sampled mid-cycle, where nothing else is moving.
  task automatic send_byte(input logic [ByteW-1:0] b);
    result_t r;
    bit      taken;
    while (gaps_on && $urandom_range(99) < 22) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    do begin
      @(negedge clk);
      taken = !data_stall;
      @(posedge clk);
    end while (!taken);
    if (deframe_byte(b, r)) deframed_q.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [ByteW-1:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drop valid, wait for every pending result, then let the pipe go quiet.
  task automatic settle();
    data_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_split(input bit on);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    split_on     = on;
  endtask

  // One chunk of random shape: mostly well-formed message runs with random
  // content, some with a trailing lone byte, some with an overstated message
  // length, and some plain noise.
  task automatic send_random_chunk();
    logic [ByteW-1:0] body[$];
    int unsigned      msg_len;
    int unsigned      shape;
    logic [LenW-1:0]  hdr;
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(12)) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(4)) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        body.push_back(msg_len[7:0]);
        body.push_back(msg_len[15:8]);
        repeat (msg_len) body.push_back(8'($urandom));
      end
      if (shape < 22) begin
        body.push_back(8'($urandom));
      end else if (shape < 32 && body.size() != 0) begin
        hdr     = {body[1], body[0]} + 16'($urandom_range(300, 1));
        body[0] = hdr[7:0];
        body[1] = hdr[15:8];
      end
    end
    hdr = 16'(body.size());
    send_byte(hdr[7:0]);
    send_byte(hdr[15:8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic run_random_chunks(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_chunk();
  endtask

  task automatic test_message_cases();
    set_split(1'b1);
    send_seq('{8'h00, 8'h00});                             // empty chunk
    send_seq('{8'h04, 8'h00, 8'h02, 8'h00, 8'h00, 8'hff}); // message fills chunk
    send_seq('{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}); // two empty messages
    send_seq('{8'h01, 8'h00, 8'h7e});                      // lone trailing byte
    send_seq('{8'h04, 8'h00, 8'hff, 8'hff, 8'h11, 8'h22}); // too long, then drop
    send_seq('{8'h02, 8'h00, 8'h01, 8'h00});               // too long, nothing left
  endtask

  task automatic test_chunk_mode();
    set_split(1'b0);
    send_seq('{8'h02, 8'h00, 8'h80, 8'h5a});
    // Header completes in chunk mode; the switch back must not affect this chunk.
    send_seq('{8'h01, 8'h00});
    set_split(1'b1);
    send_byte(8'h42);
  endtask

  task automatic test_random_split();
    set_split(1'b1);
    run_random_chunks(320);
  endtask

  task automatic test_random_chunk_mode();
    set_split(1'b0);
    run_random_chunks(200);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_split(1'b1);
    run_random_chunks(150);
    gaps_on = 1'b1;
    run_random_chunks(120);
  endtask

  // Random backpressure on the result side, shut off with the input gaps.
  always @(posedge clk) begin
    result_stall <= gaps_on && ($urandom_range(99) < 22);
  end

  // Check every result beat against the oldest pending prediction.
  always @(negedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      got.payload       = payload;
      got.byte_valid    = byte_valid;
      got.message_start = message_start;
      got.message_end   = message_end;
      got.chunk_end     = chunk_end;
      got.error_code    = err_t'(error_code);
      if (deframed_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_FAILS)
          $display("unexpected result beat: payload=%02h valid=%b err=%0d",
                   got.payload, got.byte_valid, got.error_code);
      end else begin
        want = deframed_q.pop_front();
        if (got.payload !== want.payload || got.byte_valid !== want.byte_valid ||
            got.message_start !== want.message_start ||
            got.message_end !== want.message_end ||
            got.chunk_end !== want.chunk_end || got.error_code !== want.error_code) begin
          fail_count++;
          if (fail_count <= SHOWN_FAILS)
            $display({"result mismatch: got payload=%02h valid=%b start=%b end=%b ",
                      "chunk_end=%b err=%0d, want payload=%02h valid=%b start=%b ",
                      "end=%b chunk_end=%b err=%0d"},
                     got.payload, got.byte_valid, got.message_start, got.message_end,
                     got.chunk_end, got.error_code, want.payload, want.byte_valid,
                     want.message_start, want.message_end, want.chunk_end,
                     want.error_code);
        end
      end
    end
  end

  // Hang detection: give up after a long run of cycles with no beat at all.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(negedge clk);
      if ((data_valid && !data_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("length_prefixed_chunk_deframer_core_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_message_cases();
    test_chunk_mode();
    test_random_split();
    test_random_chunk_mode();
    test_back_to_back();
    settle();
    if (deframed_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("length_prefixed_chunk_deframer_core_tb OK");
    end else begin
      $display("length_prefixed_chunk_deframer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* length_prefixed_chunk_deframer_core.f */
src/lpcd_pkg.sv
src/length_prefixed_chunk_deframer_core.sv
tb/length_prefixed_chunk_deframer_core_tb.sv
